// ----- rtl/psv_pkg.sv -----
`default_nettype none
package psv_pkg;

   localparam int ANGLE_FRAC_BITS     = 8;
   localparam int ZF                  = 20;
   localparam int ANGLE_SHIFT         = ZF - ANGLE_FRAC_BITS;
   localparam int ANGLE_W             = 32;
   localparam int TRIG_W              = 32;
   localparam int CORDIC_W            = 33;
   localparam int ATAN_LEN            = 24;
   localparam int CORDIC_STAGES_DEF   = 16;
   localparam int LANES               = 4;

   localparam int SEG_W    = 17;
   localparam int RADIUS_W = 21;
   localparam int CENTER_W = 22;
   localparam int ROT_W    = 18;
   localparam int COORD_W  = 24;
   localparam int SUM_W    = 30;

   localparam logic [ANGLE_W-1:0] TURN       = ANGLE_W'(360 << ZF);
   localparam logic [ANGLE_W-1:0] HALF_TURN  = ANGLE_W'(180 << ZF);
   localparam logic [ANGLE_W-1:0] QUARTER    = ANGLE_W'(90 << ZF);
   localparam logic [ANGLE_W-1:0] THREE_QTR  = ANGLE_W'(270 << ZF);
   localparam logic [ANGLE_W-1:0] TWO_TURNS  = ANGLE_W'(720 << ZF);
   localparam logic signed [CORDIC_W-1:0] GAIN_Q30 = CORDIC_W'(652032874);

   localparam logic [SEG_W-1:0]    SEG_RESET    = SEG_W'(46080);
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(256);

   typedef enum logic [1:0] {
      REG_SEGMENT = 2'd0,
      REG_RADIUS  = 2'd1,
      REG_CENTER_X = 2'd2,
      REG_CENTER_Y = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [SEG_W-1:0]           segment_angle;
      logic [RADIUS_W-1:0]        radius;
      logic signed [CENTER_W-1:0] center_x;
      logic signed [CENTER_W-1:0] center_y;
   } cfg_type;

   function automatic logic [ANGLE_W-1:0] atan_entry(input int idx);
      logic [ANGLE_W-1:0] v;
      case (idx)
         0:  v = ANGLE_W'(47185920);
         1:  v = ANGLE_W'(27855475);
         2:  v = ANGLE_W'(14718068);
         3:  v = ANGLE_W'(7471121);
         4:  v = ANGLE_W'(3750058);
         5:  v = ANGLE_W'(1876857);
         6:  v = ANGLE_W'(938658);
         7:  v = ANGLE_W'(469357);
         8:  v = ANGLE_W'(234682);
         9:  v = ANGLE_W'(117342);
         10: v = ANGLE_W'(58671);
         11: v = ANGLE_W'(29335);
         12: v = ANGLE_W'(14668);
         13: v = ANGLE_W'(7334);
         14: v = ANGLE_W'(3667);
         15: v = ANGLE_W'(1833);
         16: v = ANGLE_W'(917);
         17: v = ANGLE_W'(458);
         18: v = ANGLE_W'(229);
         19: v = ANGLE_W'(115);
         20: v = ANGLE_W'(57);
         21: v = ANGLE_W'(29);
         22: v = ANGLE_W'(14);
         23: v = ANGLE_W'(7);
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = SUM_W'(8388607);
      lo = -SUM_W'(8388608);
      if (v > hi) begin
         return COORD_W'(hi);
      end else if (v < lo) begin
         return COORD_W'(lo);
      end
      return v[COORD_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ----- rtl/psv_angle.sv -----
`default_nettype none
module psv_angle
   import psv_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   input  wire logic signed [ROT_W-1:0]     rotation,
   input  wire logic [SEG_W-1:0]            segment_angle,
   output logic                             out_valid,
   output logic signed [ANGLE_W-1:0]        z_out [LANES],
   output logic                             neg_out [LANES]
);

   logic                      va_ff, vb_ff, vc_ff;
   logic signed [ANGLE_W-1:0] a_ff [LANES];
   logic [ANGLE_W-1:0]        red_ff [LANES];
   logic [ANGLE_W-1:0]        red_in [LANES];
   logic signed [ANGLE_W-1:0] z_ff [LANES];
   logic signed [ANGLE_W-1:0] z_in [LANES];
   logic                      neg_ff [LANES];
   logic                      neg_in [LANES];
   logic signed [ANGLE_W-1:0] rot_w, seg_w, half_w;

   assign rot_w  = ANGLE_W'(rotation) <<< ANGLE_SHIFT;
   assign seg_w  = $signed(ANGLE_W'(segment_angle) << ANGLE_SHIFT);
   assign half_w = $signed(ANGLE_W'(segment_angle) << (ANGLE_SHIFT - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_ff[0] <= rot_w;
      a_ff[1] <= rot_w + seg_w;
      a_ff[2] <= half_w;
      a_ff[3] <= $signed(HALF_TURN) + rot_w + half_w;
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         red_in[l] = $unsigned(a_ff[l]) + TWO_TURNS;
         for (int k = 0; k < 4; k++) begin
            if (red_in[l] >= TURN) begin
               red_in[l] = red_in[l] - TURN;
            end
         end
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         neg_in[l] = 1'b0;
         z_in[l]   = $signed(red_ff[l]);
         if (red_ff[l] > QUARTER && red_ff[l] < THREE_QTR) begin
            z_in[l]   = $signed(red_ff[l] - HALF_TURN);
            neg_in[l] = 1'b1;
         end else if (red_ff[l] >= THREE_QTR) begin
            z_in[l] = $signed(red_ff[l] - TURN);
         end
      end
   end

   always_ff @(posedge clock) begin
      red_ff <= red_in;
      z_ff   <= z_in;
      neg_ff <= neg_in;
   end

   assign out_valid = vc_ff;
   assign z_out     = z_ff;
   assign neg_out   = neg_ff;

endmodule
`default_nettype wire

// ----- rtl/psv_cordic.sv -----
`default_nettype none
module psv_cordic
   import psv_pkg::*;
#(
   parameter int STAGES = CORDIC_STAGES_DEF
) (
   input  wire logic                      clock,
   input  wire logic signed [ANGLE_W-1:0] z_in,
   input  wire logic                      neg_in,
   output logic signed [TRIG_W-1:0]       cos_out,
   output logic signed [TRIG_W-1:0]       sin_out
);

   logic signed [CORDIC_W-1:0] x_src [STAGES];
   logic signed [CORDIC_W-1:0] y_src [STAGES];
   logic signed [ANGLE_W-1:0]  z_src [STAGES];
   logic                       n_src [STAGES];
   logic signed [CORDIC_W-1:0] x_ff [STAGES];
   logic signed [CORDIC_W-1:0] y_ff [STAGES];
   logic signed [ANGLE_W-1:0]  z_ff [STAGES];
   logic                       n_ff [STAGES];
   logic signed [CORDIC_W-1:0] x_end, y_end;

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      if (i == 0) begin : g_first
         assign x_src[i] = GAIN_Q30;
         assign y_src[i] = '0;
         assign z_src[i] = z_in;
         assign n_src[i] = neg_in;
      end else begin : g_next
         assign x_src[i] = x_ff[i-1];
         assign y_src[i] = y_ff[i-1];
         assign z_src[i] = z_ff[i-1];
         assign n_src[i] = n_ff[i-1];
      end

      always_ff @(posedge clock) begin
         n_ff[i] <= n_src[i];
         if (z_src[i] >= 0) begin
            x_ff[i] <= x_src[i] - (y_src[i] >>> i);
            y_ff[i] <= y_src[i] + (x_src[i] >>> i);
            z_ff[i] <= z_src[i] - $signed(atan_entry(i));
         end else begin
            x_ff[i] <= x_src[i] + (y_src[i] >>> i);
            y_ff[i] <= y_src[i] - (x_src[i] >>> i);
            z_ff[i] <= z_src[i] + $signed(atan_entry(i));
         end
      end
   end

   assign x_end   = n_ff[STAGES-1] ? -x_ff[STAGES-1] : x_ff[STAGES-1];
   assign y_end   = n_ff[STAGES-1] ? -y_ff[STAGES-1] : y_ff[STAGES-1];
   assign cos_out = x_end[TRIG_W-1:0];
   assign sin_out = y_end[TRIG_W-1:0];

endmodule
`default_nettype wire

// ----- rtl/psv_scale.sv -----
`default_nettype none
module psv_scale
   import psv_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   input  wire cfg_type                  cfg,
   input  wire logic signed [TRIG_W-1:0] c1, s1, c2, s2, ch, cd, sd,
   output logic                          out_valid,
   output logic signed [COORD_W-1:0]     first_x, first_y, second_x, second_y,
   output logic signed [COORD_W-1:0]     across_x, across_y
);

   localparam int P_W  = CENTER_W + TRIG_W;
   localparam int AP_W = CENTER_W;
   localparam int Q_W  = AP_W + 2 + TRIG_W;

   logic                      v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [P_W-1:0]     p_ff [4];
   logic [P_W-1:0]            pap_ff;
   logic signed [TRIG_W-1:0]  cd1_ff, sd1_ff, cd2_ff, sd2_ff;
   logic signed [COORD_W-1:0] vt2_ff [4];
   logic signed [COORD_W-1:0] vt3_ff [4];
   logic signed [COORD_W-1:0] vt_in [4];
   logic [AP_W-1:0]           ap_ff;
   logic [P_W:0]              ap_sum;
   logic signed [Q_W-1:0]     qx_ff, qy_ff;
   logic signed [P_W:0]       rnd [4];
   logic signed [Q_W:0]       rqx, rqy;
   logic signed [CENTER_W:0]  rad_s;
   logic [TRIG_W-1:0]         ch_abs;
   logic signed [AP_W+1:0]    ap2;
   logic signed [COORD_W-1:0] ax_ff, ay_ff;
   logic signed [SUM_W-1:0]   cx_w, cy_w;

   assign rad_s  = $signed({2'b00, cfg.radius});
   assign ch_abs = ch[TRIG_W-1] ? $unsigned(-ch) : $unsigned(ch);
   assign cx_w   = SUM_W'(cfg.center_x);
   assign cy_w   = SUM_W'(cfg.center_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      p_ff[0] <= P_W'(rad_s * c1);
      p_ff[1] <= P_W'(rad_s * s1);
      p_ff[2] <= P_W'(rad_s * c2);
      p_ff[3] <= P_W'(rad_s * s2);
      pap_ff  <= P_W'({1'b0, cfg.radius} * ch_abs);
      cd1_ff  <= cd;
      sd1_ff  <= sd;
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         rnd[k] = (P_W+1)'(p_ff[k]) + (P_W+1)'(1 << 29);
      end
      vt_in[0] = sat_coord(cx_w + SUM_W'(rnd[0] >>> 30));
      vt_in[1] = sat_coord(cy_w - SUM_W'(rnd[1] >>> 30));
      vt_in[2] = sat_coord(cx_w + SUM_W'(rnd[2] >>> 30));
      vt_in[3] = sat_coord(cy_w - SUM_W'(rnd[3] >>> 30));
   end

   assign ap_sum = {1'b0, pap_ff} + (P_W+1)'(1 << 29);

   always_ff @(posedge clock) begin
      vt2_ff <= vt_in;
      ap_ff  <= ap_sum[30 +: AP_W];
      cd2_ff <= cd1_ff;
      sd2_ff <= sd1_ff;
   end

   assign ap2 = $signed({1'b0, ap_ff, 1'b0});

   always_ff @(posedge clock) begin
      vt3_ff <= vt2_ff;
      qx_ff  <= Q_W'(ap2 * cd2_ff);
      qy_ff  <= Q_W'(ap2 * sd2_ff);
   end

   assign rqx = (Q_W+1)'(qx_ff) + (Q_W+1)'(1 << 29);
   assign rqy = (Q_W+1)'(qy_ff) + (Q_W+1)'(1 << 29);

   always_ff @(posedge clock) begin
      first_x  <= vt3_ff[0];
      first_y  <= vt3_ff[1];
      second_x <= vt3_ff[2];
      second_y <= vt3_ff[3];
      ax_ff    <= sat_coord(cx_w + SUM_W'(rqx >>> 30));
      ay_ff    <= sat_coord(cy_w - SUM_W'(rqy >>> 30));
   end

   assign across_x  = ax_ff;
   assign across_y  = ay_ff;
   assign out_valid = v4_ff;

endmodule
`default_nettype wire

// ----- rtl/polygon_segment_vertices_core.sv -----
`default_nettype none
// Regular polygon segment vertex generator.
// Input: raise start with req_rotation (signed, 1/256 degree); a word is
// taken at every edge where start is high and busy is low. busy stays low,
// so one word may enter in every clock cycle.
// Output: rsp_strobe is high for one cycle with the six coordinates of that
// word: both outer vertices of the segment and the point opposite it at
// twice the apothem, signed Q.8, saturated to 24 bits. Results leave in
// the order words entered.
// Pipeline: from the accepting edge to the edge that takes the result, a word
// passes three angle stages, one stage per CORDIC iteration in four parallel
// lanes, then four stages of scaling (two multiplier ranks, rounding,
// centering, saturation).
// Throughput: one word per cycle, set by the fully pipelined CORDIC lanes.
// Configuration: APB registers segment_angle, radius, center_x, center_y at
// byte addresses 0, 4, 8, 12; write only while no word is in flight.
// Reset clears the pipeline valid bits and loads the register defaults.
// The receiver cannot stall; every strobe must be taken in its cycle.
module polygon_segment_vertices_core
   import psv_pkg::*;
#(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic signed [ROT_W-1:0]     req_rotation,
   output logic                             rsp_strobe,
   output logic signed [COORD_W-1:0]        rsp_first_x,
   output logic signed [COORD_W-1:0]        rsp_first_y,
   output logic signed [COORD_W-1:0]        rsp_second_x,
   output logic signed [COORD_W-1:0]        rsp_second_y,
   output logic signed [COORD_W-1:0]        rsp_across_x,
   output logic signed [COORD_W-1:0]        rsp_across_y,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [3:0]                  paddr,
   input  wire logic [31:0]                 pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);

   localparam int LATENCY = CORDIC_STAGES + 7;

   cfg_type                   cfg_ff;
   logic                      wr_en;
   reg_index_type             idx;
   logic                      ang_valid;
   logic signed [ANGLE_W-1:0] z [LANES];
   logic                      neg [LANES];
   logic signed [TRIG_W-1:0]  cs [LANES];
   logic signed [TRIG_W-1:0]  sn [LANES];
   logic [CORDIC_STAGES-1:0]  cv_ff;

   assign busy   = 1'b0;
   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;
   assign idx    = reg_index_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.segment_angle <= SEG_RESET;
         cfg_ff.radius        <= RADIUS_RESET;
         cfg_ff.center_x      <= '0;
         cfg_ff.center_y      <= '0;
      end else if (wr_en) begin
         case (idx)
            REG_SEGMENT:  cfg_ff.segment_angle <= pwdata[SEG_W-1:0];
            REG_RADIUS:   cfg_ff.radius        <= pwdata[RADIUS_W-1:0];
            REG_CENTER_X: cfg_ff.center_x      <= $signed(pwdata[CENTER_W-1:0]);
            REG_CENTER_Y: cfg_ff.center_y      <= $signed(pwdata[CENTER_W-1:0]);
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_SEGMENT:  prdata = 32'(cfg_ff.segment_angle);
         REG_RADIUS:   prdata = 32'(cfg_ff.radius);
         REG_CENTER_X: prdata = 32'(cfg_ff.center_x);
         REG_CENTER_Y: prdata = 32'(cfg_ff.center_y);
         default:      prdata = '0;
      endcase
   end

   psv_angle u_angle (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (start && !busy),
      .rotation      (req_rotation),
      .segment_angle (cfg_ff.segment_angle),
      .out_valid     (ang_valid),
      .z_out         (z),
      .neg_out       (neg)
   );

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      psv_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
         .clock   (clock),
         .z_in    (z[l]),
         .neg_in  (neg[l]),
         .cos_out (cs[l]),
         .sin_out (sn[l])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff <= '0;
      end else begin
         cv_ff <= {cv_ff[CORDIC_STAGES-2:0], ang_valid};
      end
   end

   psv_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cv_ff[CORDIC_STAGES-1]),
      .cfg       (cfg_ff),
      .c1        (cs[0]),
      .s1        (sn[0]),
      .c2        (cs[1]),
      .s2        (sn[1]),
      .ch        (cs[2]),
      .cd        (cs[3]),
      .sd        (sn[3]),
      .out_valid (rsp_strobe),
      .first_x   (rsp_first_x),
      .first_y   (rsp_first_y),
      .second_x  (rsp_second_x),
      .second_y  (rsp_second_y),
      .across_x  (rsp_across_x),
      .across_y  (rsp_across_y)
   );

`ifndef SYNTHESIS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_strobe)
      else $error("accepted word did not produce a result");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |-> ##LATENCY !rsp_strobe)
      else $error("result without an accepted word");

   a_seg_write: assert property (@(posedge clock) disable iff (reset)
      (wr_en && idx == REG_SEGMENT) |=> cfg_ff.segment_angle == $past(pwdata[SEG_W-1:0]))
      else $error("segment angle register not written");
`endif

endmodule
`default_nettype wire
